// ===== hdl/ddo_pkg.sv =====
// Shared types, constants and helper functions for the differential-drive odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 8'd1;

  localparam logic [23:0] SPEED_SCALE_RST = 24'd88459;
  localparam logic [23:0] INV_SPACING_RST = 24'd327680;

  localparam int MUL_A_W = 54;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [31:0] POS_FACTOR  = 32'd2251799814;
  localparam logic [31:0] HEAD_FACTOR = 32'd2867080570;

  localparam int COR_W = 34;
  localparam logic signed [COR_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [COR_W-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic        [19:0] elapsed_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] ang_vel;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_LIN,
    OP_DV,
    OP_ANG,
    OP_VC,
    OP_VS,
    OP_PX,
    OP_DX,
    OP_PY,
    OP_DY,
    OP_PH,
    OP_DH
  } op_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ddo_mul.sv =====
// Serial shift-add multiplier: one multiplier bit per cycle, unsigned operands.
`timescale 1ns / 1ps
module ddo_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ddo_pkg::MUL_A_W-1:0]  a,
  input  logic [ddo_pkg::MUL_B_W-1:0]  b,
  output logic                         done,
  output logic [ddo_pkg::MUL_P_W-1:0]  prod
);
  localparam int CNT_W = $clog2(ddo_pkg::MUL_B_W);

  logic [ddo_pkg::MUL_A_W-1:0] a_r;
  logic [ddo_pkg::MUL_B_W-1:0] b_r;
  logic [ddo_pkg::MUL_P_W-1:0] acc_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ddo_pkg::MUL_A_W:0]   sum;

  assign sum = {1'b0, acc_r[ddo_pkg::MUL_P_W-1:ddo_pkg::MUL_B_W]}
             + {1'b0, (b_r[0] ? a_r : {ddo_pkg::MUL_A_W{1'b0}})};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(ddo_pkg::MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {sum, acc_r[ddo_pkg::MUL_B_W-1:1]};
      b_r   <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("multiplier did not start");
`endif
endmodule

// ===== hdl/ddo_cordic.sv =====
// Iterative CORDIC: one rotation step per cycle, gives cos and sin of a binary angle.
`timescale 1ns / 1ps
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);
  localparam int W = ddo_pkg::COR_W;

  logic signed [W-1:0] x_r, y_r, z_r;
  logic signed [W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [W-1:0] xs, ys, at, xc, yc;
  logic [5:0]          step_r;
  logic                flip_r;
  logic                busy_r;
  logic                done_r;
  logic                fold;
  logic [31:0]         ang_f;

  assign fold  = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
  assign ang_f = fold ? angle - ddo_pkg::HALF_TURN : angle;

  always_comb begin
    xs = x_r >>> step_r[4:0];
    ys = y_r >>> step_r[4:0];
    at = $signed({2'b00, ddo_pkg::atan_turns(step_r[4:0])});
    if (z_r >= 0) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == 6'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= ddo_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= W'($signed(ang_f));
      flip_r <= fold;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    if (x_r > ddo_pkg::ONE_Q30) xc = ddo_pkg::ONE_Q30;
    else if (x_r < -ddo_pkg::ONE_Q30) xc = -ddo_pkg::ONE_Q30;
    else xc = x_r;
    if (y_r > ddo_pkg::ONE_Q30) yc = ddo_pkg::ONE_Q30;
    else if (y_r < -ddo_pkg::ONE_Q30) yc = -ddo_pkg::ONE_Q30;
    else yc = y_r;
    if (flip_r) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign cos_q = xc[31:0];
  assign sin_q = yc[31:0];
  assign done  = done_r;
endmodule

// ===== hdl/diff_drive_odometry_unit.sv =====
// Top level of the differential-drive odometry block: sequencer, pose state and ports.
//
// Each item runs eleven products through one shared serial multiplier that retires one
// multiplier bit per cycle (it loads the operands, shifts through the multiplier bits and
// then gives the product), while the CORDIC unit works out cos and sin of the old heading in
// parallel. No new item is accepted until the result of the last one is in the result
// register and the sequencer is back in idle. A new item is accepted while the previous
// result still waits on out_ready.
`timescale 1ns / 1ps
module diff_drive_odometry_unit #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ddo_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ddo_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]    cfg_data
);
  ddo_pkg::state_t state_r, state_nxt;
  ddo_pkg::op_t    op_r;

  logic [23:0]         scale_r, inv_r;
  logic signed [31:0]  pose_x_r, pose_y_r;
  logic [31:0]         head_r;
  logic signed [15:0]  left_r, right_r;
  logic [19:0]         dt_r;
  logic signed [31:0]  lin_r, ang_r;
  logic signed [34:0]  dv_r;
  logic signed [33:0]  vc_r, vs_r;
  logic [ddo_pkg::MUL_A_W-1:0] p_mag_r;
  logic                p_neg_r;
  logic                neg_r;
  logic                out_valid_r;
  ddo_pkg::out_t       out_data_r;

  logic                mul_start, cor_start, post_en, emit_en, accept;
  logic                mul_done, cor_done;
  logic [ddo_pkg::MUL_A_W-1:0] mul_a;
  logic [ddo_pkg::MUL_B_W-1:0] mul_b;
  logic                mul_neg;
  logic [ddo_pkg::MUL_P_W-1:0] prod;
  logic signed [31:0]  cos_q, sin_q;

  // operand preparation
  logic signed [16:0]  l17, r17;
  logic signed [17:0]  sum18, diff18;
  logic [17:0]         sum_abs, diff_abs;
  logic [34:0]         dv_abs;
  logic signed [32:0]  lin33, ang33;
  logic [32:0]         lin_abs, ang_abs;
  logic [31:0]         cos_abs, sin_abs;
  logic [33:0]         vc_abs, vs_abs;

  assign l17      = {left_r[15], left_r};
  assign r17      = -{right_r[15], right_r};
  assign sum18    = {l17[16], l17} + {r17[16], r17};
  assign diff18   = {r17[16], r17} - {l17[16], l17};
  assign sum_abs  = sum18[17] ? 18'(-sum18) : 18'(sum18);
  assign diff_abs = diff18[17] ? 18'(-diff18) : 18'(diff18);
  assign dv_abs   = dv_r[34] ? 35'(-dv_r) : 35'(dv_r);
  assign lin33    = {lin_r[31], lin_r};
  assign ang33    = {ang_r[31], ang_r};
  assign lin_abs  = lin33[32] ? 33'(-lin33) : 33'(lin33);
  assign ang_abs  = ang33[32] ? 33'(-ang33) : 33'(ang33);
  assign cos_abs  = cos_q[31] ? 32'(-cos_q) : 32'(cos_q);
  assign sin_abs  = sin_q[31] ? 32'(-sin_q) : 32'(sin_q);
  assign vc_abs   = vc_r[33] ? 34'(-vc_r) : 34'(vc_r);
  assign vs_abs   = vs_r[33] ? 34'(-vs_r) : 34'(vs_r);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (op_r)
      ddo_pkg::OP_LIN: begin
        mul_a   = ddo_pkg::MUL_A_W'(sum_abs);
        mul_b   = ddo_pkg::MUL_B_W'(scale_r);
        mul_neg = sum18[17];
      end
      ddo_pkg::OP_DV: begin
        mul_a   = ddo_pkg::MUL_A_W'(diff_abs);
        mul_b   = ddo_pkg::MUL_B_W'(scale_r);
        mul_neg = diff18[17];
      end
      ddo_pkg::OP_ANG: begin
        mul_a   = ddo_pkg::MUL_A_W'(dv_abs);
        mul_b   = ddo_pkg::MUL_B_W'(inv_r);
        mul_neg = dv_r[34];
      end
      ddo_pkg::OP_VC: begin
        mul_a   = ddo_pkg::MUL_A_W'(lin_abs);
        mul_b   = cos_abs;
        mul_neg = lin_r[31] ^ cos_q[31];
      end
      ddo_pkg::OP_VS: begin
        mul_a   = ddo_pkg::MUL_A_W'(lin_abs);
        mul_b   = sin_abs;
        mul_neg = lin_r[31] ^ sin_q[31];
      end
      ddo_pkg::OP_PX: begin
        mul_a   = ddo_pkg::MUL_A_W'(vc_abs);
        mul_b   = ddo_pkg::MUL_B_W'(dt_r);
        mul_neg = vc_r[33];
      end
      ddo_pkg::OP_PY: begin
        mul_a   = ddo_pkg::MUL_A_W'(vs_abs);
        mul_b   = ddo_pkg::MUL_B_W'(dt_r);
        mul_neg = vs_r[33];
      end
      ddo_pkg::OP_PH: begin
        mul_a   = ddo_pkg::MUL_A_W'(ang_abs);
        mul_b   = ddo_pkg::MUL_B_W'(dt_r);
        mul_neg = ang_r[31];
      end
      ddo_pkg::OP_DX, ddo_pkg::OP_DY: begin
        mul_a   = p_mag_r;
        mul_b   = ddo_pkg::POS_FACTOR;
        mul_neg = p_neg_r;
      end
      ddo_pkg::OP_DH: begin
        mul_a   = p_mag_r;
        mul_b   = ddo_pkg::HEAD_FACTOR;
        mul_neg = p_neg_r;
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  // result shaping
  logic signed [65:0] sp, sp_r8, sp_r9, sp_r16, sp_r30, ang_t;
  logic [ddo_pkg::MUL_P_W-1:0] pm_sum, hm_sum;
  logic [34:0]        pos_m;
  logic signed [35:0] pos_d;
  logic signed [65:0] pos_new;
  logic signed [31:0] pos_sat;
  logic [31:0]        head_m, head_d;

  always_comb begin
    sp      = neg_r ? -$signed(prod[65:0]) : $signed(prod[65:0]);
    sp_r8   = sp + 66'sd128;
    sp_r9   = sp + 66'sd256;
    sp_r16  = sp + 66'sd32768;
    sp_r30  = sp + 66'sd536870912;
    ang_t   = sp_r16 >>> 16;
    pm_sum  = prod + (ddo_pkg::MUL_P_W'(1) << 50);
    hm_sum  = prod + (ddo_pkg::MUL_P_W'(1) << 37);
    pos_m   = pm_sum[85:51];
    pos_d   = neg_r ? -$signed({1'b0, pos_m}) : $signed({1'b0, pos_m});
    pos_new = (op_r == ddo_pkg::OP_DX) ? 66'(pose_x_r) + 66'(pos_d)
                                       : 66'(pose_y_r) + 66'(pos_d);
    pos_sat = ddo_pkg::sat32(pos_new);
    head_m  = hm_sum[69:38];
    head_d  = neg_r ? -head_m : head_m;
  end

  // sequencer
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    cor_start = 1'b0;
    post_en   = 1'b0;
    emit_en   = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      ddo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cor_start = 1'b1;
          state_nxt = ddo_pkg::ST_LOAD;
        end
      end
      ddo_pkg::ST_LOAD: begin
        if ((op_r != ddo_pkg::OP_VC && op_r != ddo_pkg::OP_VS) || cor_done) begin
          mul_start = 1'b1;
          state_nxt = ddo_pkg::ST_MUL;
        end
      end
      ddo_pkg::ST_MUL: begin
        if (mul_done) begin
          post_en   = 1'b1;
          state_nxt = (op_r == ddo_pkg::OP_DH) ? ddo_pkg::ST_EMIT : ddo_pkg::ST_LOAD;
        end
      end
      ddo_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit_en   = 1'b1;
          state_nxt = ddo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ddo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddo_pkg::ST_IDLE;
      op_r        <= ddo_pkg::OP_LIN;
      out_valid_r <= 1'b0;
      scale_r     <= ddo_pkg::SPEED_SCALE_RST;
      inv_r       <= ddo_pkg::INV_SPACING_RST;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      head_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_index == ddo_pkg::REG_SPEED_SCALE) scale_r <= cfg_data;
      if (cfg_valid && cfg_index == ddo_pkg::REG_INV_SPACING) inv_r <= cfg_data;
      if (accept) op_r <= ddo_pkg::OP_LIN;
      else if (post_en && op_r != ddo_pkg::OP_DH) op_r <= ddo_pkg::op_t'(op_r + 4'd1);
      if (post_en && op_r == ddo_pkg::OP_DX) pose_x_r <= pos_sat;
      if (post_en && op_r == ddo_pkg::OP_DY) pose_y_r <= pos_sat;
      if (post_en && op_r == ddo_pkg::OP_DH) head_r <= head_r + head_d;
      if (emit_en) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_r  <= in_data.left_speed;
      right_r <= in_data.right_speed;
      dt_r    <= in_data.elapsed_us;
    end
    if (mul_start) neg_r <= mul_neg;
    if (post_en) begin
      case (op_r)
        ddo_pkg::OP_LIN: lin_r <= sp_r9[40:9];
        ddo_pkg::OP_DV:  dv_r  <= sp_r8[42:8];
        ddo_pkg::OP_ANG: ang_r <= ddo_pkg::sat32(ang_t);
        ddo_pkg::OP_VC:  vc_r  <= sp_r30[63:30];
        ddo_pkg::OP_VS:  vs_r  <= sp_r30[63:30];
        ddo_pkg::OP_PX, ddo_pkg::OP_PY, ddo_pkg::OP_PH: begin
          p_mag_r <= prod[ddo_pkg::MUL_A_W-1:0];
          p_neg_r <= neg_r;
        end
        default: ;
      endcase
    end
    if (emit_en) begin
      out_data_r.pos_x   <= pose_x_r;
      out_data_r.pos_y   <= pose_y_r;
      out_data_r.heading <= head_r;
      out_data_r.lin_vel <= lin_r;
      out_data_r.ang_vel <= ang_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (head_r),
    .done  (cor_done),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

`ifndef ASSERT_OFF
  a_cor_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cor_done) |-> state_r != ddo_pkg::ST_IDLE)
    else $error("cordic finished with no item in flight");
`endif
`ifndef ASSERT_OFF
  a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ddo_pkg::ST_MUL)
    else $error("product ready outside multiply state");
`endif
`ifndef ASSERT_OFF
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en |=> out_valid_r && state_r == ddo_pkg::ST_IDLE)
    else $error("result not presented after emit");
`endif
endmodule

// ===== tb/sv/diff_drive_odometry_unit_tb.sv =====
// Self-checking testbench for diff_drive_odometry_unit against a pose predictor.
`timescale 1ns / 1ps
module diff_drive_odometry_unit_tb;

  localparam int STALL_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [ddo_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint UNIT_Q30 = 1073741824;
  localparam int POS_SHIFT = 51;
  localparam int HEAD_SHIFT = 38;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ddo_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  ddo_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data;

  diff_drive_odometry_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // atan(2^-i) in units of 2^-32 turn
  logic [31:0] atan_tab [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087, 32'd667544,
    32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
    32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20, 32'd10,
    32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  logic [23:0] model_scale;
  logic [23:0] model_inv_spacing;
  longint model_x;
  longint model_y;
  logic [31:0] model_heading;

  ddo_pkg::out_t pose_q[$];
  int mismatches;
  int idle_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > UNIT_Q30) return UNIT_Q30;
    if (v < -UNIT_Q30) return -UNIT_Q30;
    return v;
  endfunction

  // magnitude of p * c / 2^s rounded half up, sign restored
  function automatic longint scaled_delta(longint p, logic [31:0] c, int s);
    logic [127:0] m;
    longint mag;
    mag = (p < 0) ? -p : p;
    m = (128'(mag) * 128'(c) + (128'd1 << (s - 1))) >> s;
    return (p < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic void heading_cos_sin(logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, xs, ys;
    a = ang;
    flip = 1'b0;
    if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
      a = a - ddo_pkg::HALF_TURN;
      flip = 1'b1;
    end
    z = longint'(signed'(a));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ddo_pkg::CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_tab[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_tab[i]);
      end
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic ddo_pkg::out_t odometry_step(ddo_pkg::in_t d);
    longint l, r, dt, lin, dv, ang, cs, sn, vc, vs;
    ddo_pkg::out_t o;
    l = longint'(d.left_speed);
    r = -longint'(d.right_speed);
    dt = longint'(d.elapsed_us);
    lin = round_shift((l + r) * longint'(model_scale), 9);
    dv = round_shift((r - l) * longint'(model_scale), 8);
    ang = clamp32(round_shift(dv * longint'(model_inv_spacing), 16));
    heading_cos_sin(model_heading, cs, sn);
    vc = round_shift(lin * cs, 30);
    vs = round_shift(lin * sn, 30);
    model_x = clamp32(model_x + scaled_delta(vc * dt, ddo_pkg::POS_FACTOR, POS_SHIFT));
    model_y = clamp32(model_y + scaled_delta(vs * dt, ddo_pkg::POS_FACTOR, POS_SHIFT));
    model_heading = model_heading
                  + 32'(scaled_delta(ang * dt, ddo_pkg::HEAD_FACTOR, HEAD_SHIFT));
    o.pos_x = model_x[31:0];
    o.pos_y = model_y[31:0];
    o.heading = model_heading;
    o.lin_vel = lin[31:0];
    o.ang_vel = ang[31:0];
    return o;
  endfunction

  always @(posedge clk) begin
    ddo_pkg::out_t exp_pose;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %p", out_data);
        end else begin
          exp_pose = pose_q.pop_front();
          if (out_data.pos_x !== exp_pose.pos_x || out_data.pos_y !== exp_pose.pos_y ||
              out_data.heading !== exp_pose.heading || out_data.lin_vel !== exp_pose.lin_vel ||
              out_data.ang_vel !== exp_pose.ang_vel) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch x %0d/%0d y %0d/%0d hdg %h/%h v %0d/%0d w %0d/%0d (exp/got)",
                       exp_pose.pos_x, out_data.pos_x, exp_pose.pos_y, out_data.pos_y,
                       exp_pose.heading, out_data.heading, exp_pose.lin_vel, out_data.lin_vel,
                       exp_pose.ang_vel, out_data.ang_vel);
            end
          end
        end
      end
      if (in_valid && in_ready) pose_q.push_back(odometry_step(in_data));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ddo_pkg::REG_SPEED_SCALE) model_scale = cfg_data;
        else if (cfg_index == ddo_pkg::REG_INV_SPACING) model_inv_spacing = cfg_data;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** diff_drive_odometry_unit: FAILED **");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic signed [15:0] left, input logic signed [15:0] right,
                           input logic [19:0] dt);
    ddo_pkg::in_t d;
    d.left_speed = left;
    d.right_speed = right;
    d.elapsed_us = dt;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddo_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      send_item(16'($signed($urandom_range(6000)) - 3000),
                16'($signed($urandom_range(6000)) - 3000),
                20'($urandom_range(20000)));
    end else if (kind < 92) begin
      send_item(16'($urandom), 16'($urandom), 20'($urandom_range(1048575)));
    end else begin
      send_item($urandom_range(1) ? 16'sh7fff : 16'sh8000,
                $urandom_range(1) ? 16'sh7fff : 16'sh8000,
                $urandom_range(1) ? 20'hfffff : 20'($urandom_range(3)));
    end
  endtask

  task automatic test_directed();
    send_item(16'sd0, 16'sd0, 20'd0);
    send_item(16'sd100, -16'sd100, 20'd10000);
    send_item(16'sd1000, -16'sd1000, 20'd0);
    send_item(16'sd500, 16'sd500, 20'd10000);
    send_item(16'sd32767, -16'sd32768, 20'hfffff);
    send_item(16'sd0, -16'sd32768, 20'd1);
    send_item(-16'sd32768, 16'sd32767, 20'hfffff);
    send_item(16'sd32767, 16'sd32767, 20'hfffff);
    send_item(-16'sd32768, -16'sd32768, 20'hfffff);
    send_item(16'sd2000, 16'sd1000, 20'd500000);
    send_item(16'sd2000, -16'sd2000, 20'd250000);
    send_item(-16'sd1500, -16'sd900, 20'd800000);
    send_item(16'sd3000, -16'sd3000, 20'd40000);
    send_item(-16'sd1, 16'sd1, 20'h55555);
    send_item(16'sd1, -16'sd1, 20'haaaaa);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(ddo_pkg::REG_SPEED_SCALE, 24'hffffff);
    write_reg(ddo_pkg::REG_INV_SPACING, 24'hffffff);
    for (int i = 0; i < 6; i++) send_item(16'sd32767, -16'sd32768, 20'hfffff);
    send_item(16'sd32767, 16'sd32767, 20'hfffff);
    send_item(-16'sd32768, 16'sd32767, 20'hfffff);
    for (int i = 0; i < 20; i++) send_random_item();
    wait_idle();
    write_reg(ddo_pkg::REG_SPEED_SCALE, 24'd0);
    write_reg(ddo_pkg::REG_INV_SPACING, 24'd0);
    for (int i = 0; i < 10; i++) send_random_item();
    wait_idle();
    write_reg(REG_UNUSED, 24'h123456);
    write_reg(ddo_pkg::REG_SPEED_SCALE, 24'($urandom_range(16777215)));
    write_reg(ddo_pkg::REG_INV_SPACING, 24'($urandom_range(16777215)));
    for (int i = 0; i < 20; i++) send_random_item();
    wait_idle();
    write_reg(ddo_pkg::REG_SPEED_SCALE, ddo_pkg::SPEED_SCALE_RST);
    write_reg(ddo_pkg::REG_INV_SPACING, ddo_pkg::INV_SPACING_RST);
    for (int i = 0; i < 10; i++) send_random_item();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) send_random_item();
    wait_idle();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 1500;
    for (int i = 0; i < 12; i++) send_random_item();
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 26;
    recv_idle_pct = 63;
    model_scale = ddo_pkg::SPEED_SCALE_RST;
    model_inv_spacing = ddo_pkg::INV_SPACING_RST;
    model_x = 0;
    model_y = 0;
    model_heading = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_extremes();
    test_random_traffic(26, 63, 140);
    test_random_traffic(63, 26, 140);
    test_random_traffic(0, 0, 140);
    test_output_stall();

    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("** diff_drive_odometry_unit: PASSED **");
    end else begin
      $display("** diff_drive_odometry_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ddo_pkg.sv
hdl/ddo_mul.sv
hdl/ddo_cordic.sv
hdl/diff_drive_odometry_unit.sv
tb/sv/diff_drive_odometry_unit_tb.sv
